// ===== rtl/core/lpmd_pkg.sv =====
// Shared types and codes for the length-prefixed message deframer.
// No dependencies; imported by every module of the block.
package lpmd_pkg;

  // Header layout defaults (bytes of id, bytes of body length)
  localparam int unsigned ID_BYTES_DEF     = 2;
  localparam int unsigned LENGTH_BYTES_DEF = 2;

  localparam int unsigned ID_W    = 16;
  localparam int unsigned LEN_W   = 16;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned KIND_W  = 2;
  localparam int unsigned APB_AW  = 3;
  localparam int unsigned APB_DW  = 32;

  localparam logic [LEN_W-1:0] LIMIT_RST = 16'd2048;

  // Register index of length_limit
  localparam logic [0:0] REG_LENGTH_LIMIT = 1'b0;

  // Parser phase codes
  localparam logic [1:0] PH_HEADER = 2'd0;
  localparam logic [1:0] PH_BODY   = 2'd1;
  localparam logic [1:0] PH_HALT   = 2'd2;

  typedef enum logic [KIND_W-1:0] {
    KIND_BODY   = 2'd0,
    KIND_EMPTY  = 2'd1,
    KIND_REJECT = 2'd2
  } kind_e;

  typedef struct packed {
    logic              valid;
    kind_e             kind;
    logic [ID_W-1:0]   id;
    logic [BYTE_W-1:0] body_byte;
    logic              last;
  } res_t;

endpackage

// ===== rtl/core/lpmd_cfg.sv =====
// APB register file of the deframer: holds length_limit.
// Depends on lpmd_pkg.
module lpmd_cfg import lpmd_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output logic [LEN_W-1:0]  limit_o
);

  logic [LEN_W-1:0] limit_q, limit_d;
  logic             hit;

  assign hit    = (paddr[APB_AW-1:2] == REG_LENGTH_LIMIT);
  assign pready = 1'b1;

  always_comb begin
    limit_d = limit_q;
    if (psel && penable && pwrite && hit) begin
      limit_d = pwdata[LEN_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LIMIT_RST;
    end else begin
      limit_q <= limit_d;
    end
  end

  assign prdata  = hit ? APB_DW'(limit_q) : '0;
  assign limit_o = limit_q;

endmodule

// ===== rtl/core/lpmd_parse.sv =====
// Input register and header/body parser of the deframer.
// Depends on lpmd_pkg.
module lpmd_parse import lpmd_pkg::*; #(
  parameter int unsigned ID_BYTES     = ID_BYTES_DEF,
  parameter int unsigned LENGTH_BYTES = LENGTH_BYTES_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [BYTE_W-1:0] data_byte_i,
  input  logic              link_error_i,
  input  logic [LEN_W-1:0]  limit_i,
  input  logic              adv_i,
  output res_t              res_o
);

  localparam int unsigned HDR_BYTES = ID_BYTES + LENGTH_BYTES;
  localparam int unsigned HDR_W     = 8 * HDR_BYTES;
  localparam int unsigned HID_W     = 8 * ID_BYTES;
  localparam int unsigned HLEN_W    = 8 * LENGTH_BYTES;
  localparam int unsigned CNT_W     = $clog2(HDR_BYTES);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(HDR_BYTES - 1);

  logic              in_valid_q, in_valid_d;
  logic [BYTE_W-1:0] data_q;
  logic              err_q;
  logic              step;

  logic [1:0]        phase_q, phase_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [HDR_W-1:0]  hdr_q, hdr_d, hdr_next;
  logic [ID_W-1:0]   id_q, id_d, hdr_id;
  logic [LEN_W-1:0]  len_q, len_d, hdr_len;
  logic [LEN_W-1:0]  bcnt_q, bcnt_d;

  assign in_ready_o = !in_valid_q || adv_i;
  assign step       = in_valid_q && adv_i;

  assign hdr_next = {hdr_q[HDR_W-BYTE_W-1:0], data_q};
  assign hdr_id   = ID_W'(hdr_next[HDR_W-1 -: HID_W]);
  assign hdr_len  = LEN_W'(hdr_next[HLEN_W-1:0]);

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_ready_o) begin
      in_valid_d = in_valid_i;
    end
  end

  always_comb begin
    phase_d = phase_q;
    cnt_d   = cnt_q;
    hdr_d   = hdr_q;
    id_d    = id_q;
    len_d   = len_q;
    bcnt_d  = bcnt_q;
    res_o   = '0;
    if (step) begin
      case (phase_q)
        PH_HEADER: begin
          if (err_q) begin
            phase_d = PH_HALT;
          end else begin
            hdr_d = hdr_next;
            if (cnt_q == CNT_LAST) begin
              cnt_d  = '0;
              id_d   = hdr_id;
              len_d  = hdr_len;
              bcnt_d = '0;
              res_o.id = hdr_id;
              if (hdr_id > limit_i || hdr_len > limit_i) begin
                phase_d     = PH_HALT;
                res_o.valid = 1'b1;
                res_o.kind  = KIND_REJECT;
              end else if (hdr_len == '0) begin
                hdr_d       = '0;
                res_o.valid = 1'b1;
                res_o.kind  = KIND_EMPTY;
                res_o.last  = 1'b1;
              end else begin
                phase_d = PH_BODY;
              end
            end else begin
              cnt_d = cnt_q + CNT_W'(1);
            end
          end
        end
        PH_BODY: begin
          if (err_q) begin
            phase_d = PH_HALT;
          end else begin
            bcnt_d          = bcnt_q + LEN_W'(1);
            res_o.valid     = 1'b1;
            res_o.kind      = KIND_BODY;
            res_o.id        = id_q;
            res_o.body_byte = data_q;
            if (bcnt_d == len_q) begin
              res_o.last = 1'b1;
              phase_d    = PH_HEADER;
              hdr_d      = '0;
            end
          end
        end
        default: begin
          // halted: drop the byte
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      phase_q    <= PH_HEADER;
      cnt_q      <= '0;
      hdr_q      <= '0;
      id_q       <= '0;
      len_q      <= '0;
      bcnt_q     <= '0;
    end else begin
      in_valid_q <= in_valid_d;
      phase_q    <= phase_d;
      cnt_q      <= cnt_d;
      hdr_q      <= hdr_d;
      id_q       <= id_d;
      len_q      <= len_d;
      bcnt_q     <= bcnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o) begin
      data_q <= data_byte_i;
      err_q  <= link_error_i;
    end
  end

endmodule

// ===== rtl/core/lpmd_obuf.sv =====
// Output register of the deframer: holds one result until taken.
// Depends on lpmd_pkg.
module lpmd_obuf import lpmd_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  res_t              res_i,
  output logic              adv_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [KIND_W-1:0] kind_o,
  output logic [ID_W-1:0]   message_id_o,
  output logic [BYTE_W-1:0] body_byte_o,
  output logic              last_o
);

  logic vld_q, vld_d;
  res_t res_q;

  assign adv_o = !vld_q || out_ready_i;

  always_comb begin
    vld_d = vld_q;
    if (adv_o) begin
      vld_d = res_i.valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_o) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o  = vld_q;
  assign kind_o       = res_q.kind;
  assign message_id_o = res_q.id;
  assign body_byte_o  = res_q.body_byte;
  assign last_o       = res_q.last;

endmodule

// ===== rtl/core/length_prefixed_message_deframer.sv =====
// Length-prefixed message deframer, top level. Takes one stream byte per request
// and splits the stream into messages of a header (ID_BYTES big-endian id bytes,
// then LENGTH_BYTES big-endian body-length bytes) followed by that many body bytes.
// Every body byte comes out with its message id; the final one carries last. A
// zero-length body yields one empty-message result (kind 1, last set). A header
// whose id or length exceeds length_limit (APB register at address 0, reset 2048)
// yields one reject result (kind 2) and halts the block; a link error halts it
// without a result. Once halted, every byte is dropped until reset. Only the last
// header byte can yield a result (empty or reject). Throughput is one byte per
// clock while the output side keeps up: a byte is captured in an input register,
// parsed by combinational logic and lands in an output register, from which its
// result is presented. Depends on lpmd_pkg, lpmd_cfg, lpmd_parse and lpmd_obuf.
module length_prefixed_message_deframer import lpmd_pkg::*; #(
  parameter int unsigned ID_BYTES     = ID_BYTES_DEF,
  parameter int unsigned LENGTH_BYTES = LENGTH_BYTES_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // byte stream in
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [BYTE_W-1:0] data_byte_i,
  input  logic              link_error_i,
  // results out
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [KIND_W-1:0] kind_o,
  output logic [ID_W-1:0]   message_id_o,
  output logic [BYTE_W-1:0] body_byte_o,
  output logic              last_o,
  // configuration
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  logic [LEN_W-1:0] limit;
  logic             adv;   // output register can take a new result
  res_t             res;

  lpmd_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .limit_o (limit)
  );

  // Hold the byte in the input register and advance it only when the
  // output register is free or being drained.
  lpmd_parse #(
    .ID_BYTES     (ID_BYTES),
    .LENGTH_BYTES (LENGTH_BYTES)
  ) u_parse (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .data_byte_i  (data_byte_i),
    .link_error_i (link_error_i),
    .limit_i      (limit),
    .adv_i        (adv),
    .res_o        (res)
  );

  lpmd_obuf u_obuf (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .res_i        (res),
    .adv_o        (adv),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .kind_o       (kind_o),
    .message_id_o (message_id_o),
    .body_byte_o  (body_byte_o),
    .last_o       (last_o)
  );

`ifndef SYNTHESIS
  // Input side stalls only behind a full, stalled output register.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_o && !out_ready_i))
    else $error("input stalled without output back-pressure");

  // A reject halts the parser: nothing follows it.
  a_halt_after_reject: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && kind_o == KIND_REJECT) |=> !out_valid_o)
    else $error("result after header reject");

  // An empty message is always marked last and carries no byte.
  a_empty_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && kind_o == KIND_EMPTY) |-> (last_o && body_byte_o == '0))
    else $error("empty message without last mark");
`endif

endmodule
